@@ hw/rtl/fkin_pkg.sv @@
// Shared types and constants for the arm forward kinematics unit.
// No dependencies.
`timescale 1ns / 1ps
package fkin_pkg;

    localparam int LANES       = 4;
    localparam int SIN_STEPS   = 5;
    localparam int COS_STEPS   = 6;
    localparam int STEP_DEPTH  = 3;
    localparam int SERIES_LAT  = COS_STEPS * STEP_DEPTH;
    localparam int LANE_LAT    = 3 + SERIES_LAT + 2;
    localparam int MERGE_LAT   = 6;
    localparam int PIPE_LAT    = 2 + LANE_LAT + MERGE_LAT;

    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [33:0] K_RADIANS   = 34'd5468522205;
    localparam logic [33:0] K_DEGREES   = 34'd12216795864;

    localparam int unsigned SIN_DIV [SIN_STEPS] = '{110, 72, 42, 20, 6};
    localparam int unsigned COS_DIV [COS_STEPS] = '{132, 90, 56, 30, 12, 2};

    localparam logic signed [17:0] POS_MAX = 18'sd131071;
    localparam logic signed [17:0] POS_MIN = -18'sd131072;

    localparam logic [2:0] REG_ANGLE_UNIT      = 3'd0;
    localparam logic [2:0] REG_BASE_HEIGHT     = 3'd1;
    localparam logic [2:0] REG_SHOULDER_HEIGHT = 3'd2;
    localparam logic [2:0] REG_UPPER_LINK      = 3'd3;
    localparam logic [2:0] REG_LOWER_LINK      = 3'd4;
    localparam logic [2:0] REG_TOOL_LINK       = 3'd5;
    localparam logic [2:0] REG_SHOULDER_OFFSET = 3'd6;

    typedef struct packed {
        logic        angle_unit;
        logic [15:0] base_height;
        logic [15:0] shoulder_height;
        logic [15:0] upper_link;
        logic [15:0] lower_link;
        logic [15:0] tool_link;
        logic [15:0] shoulder_offset;
    } fkin_cfg_t;

    typedef struct packed {
        logic signed [31:0] s;
        logic signed [31:0] c;
    } fkin_trig_t;

endpackage

@@ hw/rtl/fkin_if.sv @@
// Valid/ready channel interfaces: joint angle words in, position words out.
// No dependencies.
`timescale 1ns / 1ps
interface fkin_joint_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] joint0_angle;
    logic signed [15:0] joint1_angle;
    logic signed [15:0] joint2_angle;
    logic signed [15:0] joint3_angle;

    modport source (output valid, joint0_angle, joint1_angle, joint2_angle, joint3_angle,
                    input ready);
    modport sink (input valid, joint0_angle, joint1_angle, joint2_angle, joint3_angle,
                  output ready);
endinterface

interface fkin_pos_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] pos_x;
    logic signed [17:0] pos_y;
    logic signed [17:0] pos_z;

    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

@@ hw/rtl/fkin_series_step.sv @@
// One pipelined Horner step t' = 1 - (x2*t)/div, three register stages.
// Depends on fkin_pkg.
`timescale 1ns / 1ps
module fkin_series_step #(
    parameter int unsigned DIV = 2
) (
    input  logic        clk,
    input  logic        en,
    input  logic [29:0] x2,
    input  logic [30:0] t_in,
    output logic [30:0] t_out
);
    import fkin_pkg::*;

    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIV);
    localparam logic [7:0]  DIV_C = 8'(DIV);

    logic [29:0] p_reg;
    logic [29:0] p2_reg;
    logic [29:0] q_reg;
    logic [30:0] t_reg;
    logic [60:0] pa;
    logic [61:0] mb;
    logic [37:0] qk;
    logic [37:0] rem;
    logic [29:0] qf;
    logic [30:0] t_next;

    assign pa     = 61'(x2) * 61'(t_in);
    assign mb     = 62'(p_reg) * 62'(RECIP);
    // reciprocal estimate is low by at most one
    assign qk     = 38'(q_reg) * 38'(DIV_C);
    assign rem    = 38'(p2_reg) - qk;
    assign qf     = q_reg + 30'(rem >= 38'(DIV_C));
    assign t_next = ONE_Q30 - 31'(qf);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg  <= pa[59:30];
            q_reg  <= mb[61:32];
            p2_reg <= p_reg;
            t_reg  <= t_next;
        end
    end

    assign t_out = t_reg;

endmodule

@@ hw/rtl/fkin_trig_lane.sv @@
// Sine/cosine lane: phase fold, series pipeline and quadrant mapping.
// Depends on fkin_pkg and fkin_series_step.
`timescale 1ns / 1ps
module fkin_trig_lane (
    input  logic                clk,
    input  logic                en,
    input  logic [31:0]         phase,
    output fkin_pkg::fkin_trig_t trig
);
    import fkin_pkg::*;

    logic [1:0]  quad1_reg;
    logic        fold1_reg;
    logic [29:0] rr1_reg;
    logic [1:0]  quad2_reg;
    logic        fold2_reg;
    logic [29:0] x_reg;
    logic [29:0] rem;
    logic        fold_c;
    logic [60:0] xp;
    logic [59:0] sq;

    logic [29:0] x_d    [0:SERIES_LAT];
    logic [1:0]  quad_d [0:SERIES_LAT];
    logic        fold_d [0:SERIES_LAT];
    logic [29:0] x2_d   [0:SERIES_LAT-STEP_DEPTH];

    logic [30:0] ts [0:COS_STEPS];
    logic [30:0] tc [0:COS_STEPS];

    logic [29:0] sf_reg;
    logic [30:0] cf_reg;
    logic [1:0]  quadf_reg;
    logic        foldf_reg;
    logic [60:0] fp;
    fkin_trig_t  trig_reg;
    fkin_trig_t  trig_next;
    logic signed [31:0] sv;
    logic signed [31:0] cv;

    assign rem    = phase[29:0];
    assign fold_c = rem > 30'h2000_0000;
    assign xp     = 61'(rr1_reg) * 61'(HALF_PI_Q30);
    assign sq     = 60'(x_reg) * 60'(x_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quad1_reg <= phase[31:30];
            fold1_reg <= fold_c;
            rr1_reg   <= fold_c ? 30'(ONE_Q30 - 31'(rem)) : rem;
            quad2_reg <= quad1_reg;
            fold2_reg <= fold1_reg;
            x_reg     <= xp[59:30];
            x_d[0]    <= x_reg;
            x2_d[0]   <= sq[59:30];
            quad_d[0] <= quad2_reg;
            fold_d[0] <= fold2_reg;
            for (int i = 0; i < SERIES_LAT; i++)
            begin
                x_d[i+1]    <= x_d[i];
                quad_d[i+1] <= quad_d[i];
                fold_d[i+1] <= fold_d[i];
            end
            for (int i = 0; i < SERIES_LAT - STEP_DEPTH; i++)
            begin
                x2_d[i+1] <= x2_d[i];
            end
        end
    end

    assign ts[0] = ONE_Q30;
    assign tc[0] = ONE_Q30;

    for (genvar j = 0; j < COS_STEPS; j++)
    begin : g_step
        fkin_series_step #(.DIV(COS_DIV[j])) u_cos (
            .clk   (clk),
            .en    (en),
            .x2    (x2_d[j*STEP_DEPTH]),
            .t_in  (tc[j]),
            .t_out (tc[j+1])
        );
        if (j < SIN_STEPS)
        begin : g_sin
            fkin_series_step #(.DIV(SIN_DIV[j])) u_sin (
                .clk   (clk),
                .en    (en),
                .x2    (x2_d[j*STEP_DEPTH]),
                .t_in  (ts[j]),
                .t_out (ts[j+1])
            );
        end
        else
        begin : g_sin_pass
            logic [30:0] tp_reg [0:STEP_DEPTH-1];
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    tp_reg[0] <= ts[j];
                    for (int k = 1; k < STEP_DEPTH; k++)
                    begin
                        tp_reg[k] <= tp_reg[k-1];
                    end
                end
            end
            assign ts[j+1] = tp_reg[STEP_DEPTH-1];
        end
    end

    assign fp = 61'(x_d[SERIES_LAT]) * 61'(ts[COS_STEPS]);

    always_comb
    begin
        sv = foldf_reg ? 32'(cf_reg) : 32'(sf_reg);
        cv = foldf_reg ? 32'(sf_reg) : 32'(cf_reg);
        case (quadf_reg)
            2'd0:
            begin
                trig_next.s = sv;
                trig_next.c = cv;
            end
            2'd1:
            begin
                trig_next.s = cv;
                trig_next.c = -sv;
            end
            2'd2:
            begin
                trig_next.s = -sv;
                trig_next.c = -cv;
            end
            default:
            begin
                trig_next.s = -cv;
                trig_next.c = sv;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sf_reg    <= fp[59:30];
            cf_reg    <= tc[COS_STEPS];
            quadf_reg <= quad_d[SERIES_LAT];
            foldf_reg <= fold_d[SERIES_LAT];
            trig_reg  <= trig_next;
        end
    end

    assign trig = trig_reg;

endmodule

@@ hw/rtl/fkin_merge.sv @@
// Merging stage: combines lane sine/cosine words with link lengths into x, y, z.
// Depends on fkin_pkg.
`timescale 1ns / 1ps
module fkin_merge (
    input  logic                       clk,
    input  logic                       en,
    input  fkin_pkg::fkin_cfg_t        cfg,
    input  fkin_pkg::fkin_trig_t       trig [fkin_pkg::LANES],
    output logic signed [17:0]         pos_x,
    output logic signed [17:0]         pos_y,
    output logic signed [17:0]         pos_z
);
    import fkin_pkg::*;

    function automatic logic signed [31:0] rnd30(input logic signed [61:0] v);
        logic signed [61:0] t;
        t = (v + 62'sd536870912) >>> 30;
        return 32'(t);
    endfunction

    function automatic logic signed [17:0] finish(input logic signed [31:0] v);
        logic signed [31:0] q;
        q = (v + 32'sd128) >>> 8;
        if (q > 32'(POS_MAX))
            return POS_MAX;
        else if (q < 32'(POS_MIN))
            return POS_MIN;
        else
            return 18'(q);
    endfunction

    logic signed [24:0] l0, l1, l2, l3, l4, off;
    logic signed [56:0] a_reg, b_reg, c_reg, d_reg;
    logic signed [27:0] u_reg, w_reg;
    logic signed [59:0] uc_reg, ws_reg, wc_reg, us_reg;
    logic signed [29:0] r_reg, z4_reg, z5_reg;
    logic signed [61:0] xp_reg, yp_reg;
    logic signed [31:0] s0_d [0:3];
    logic signed [31:0] c0_d [0:3];
    logic signed [31:0] s1_d [0:1];
    logic signed [31:0] c1_d [0:1];
    logic signed [17:0] x_reg, y_reg, z_reg;

    assign l0  = $signed({1'b0, cfg.base_height, 8'h00});
    assign l1  = $signed({1'b0, cfg.shoulder_height, 8'h00});
    assign l2  = $signed({1'b0, cfg.upper_link, 8'h00});
    assign l3  = $signed({1'b0, cfg.lower_link, 8'h00});
    assign l4  = $signed({1'b0, cfg.tool_link, 8'h00});
    assign off = $signed({1'b0, cfg.shoulder_offset, 8'h00});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg   <= 57'(l3) * 57'(trig[2].c);
            b_reg   <= 57'(l4) * 57'(trig[3].c);
            c_reg   <= 57'(l3) * 57'(trig[2].s);
            d_reg   <= 57'(l4) * 57'(trig[3].s);
            s0_d[0] <= trig[0].s;
            c0_d[0] <= trig[0].c;
            s1_d[0] <= trig[1].s;
            c1_d[0] <= trig[1].c;
            for (int i = 1; i < 4; i++)
            begin
                s0_d[i] <= s0_d[i-1];
                c0_d[i] <= c0_d[i-1];
            end
            s1_d[1] <= s1_d[0];
            c1_d[1] <= c1_d[0];

            u_reg <= 28'(-(rnd30(62'(a_reg)) + rnd30(62'(b_reg))));
            w_reg <= 28'(32'(l2) - rnd30(62'(c_reg)) - rnd30(62'(d_reg)));

            uc_reg <= 60'(u_reg) * 60'(c1_d[1]);
            ws_reg <= 60'(w_reg) * 60'(s1_d[1]);
            wc_reg <= 60'(w_reg) * 60'(c1_d[1]);
            us_reg <= 60'(u_reg) * 60'(s1_d[1]);

            r_reg  <= 30'(rnd30(62'(uc_reg)) + rnd30(62'(ws_reg)) + 32'(off));
            z4_reg <= 30'(rnd30(62'(wc_reg)) - rnd30(62'(us_reg)) + 32'(l1) + 32'(l0));

            xp_reg <= 62'(r_reg) * 62'(c0_d[3]);
            yp_reg <= 62'(r_reg) * 62'(s0_d[3]);
            z5_reg <= z4_reg;

            x_reg <= finish(rnd30(xp_reg));
            y_reg <= finish(rnd30(yp_reg));
            z_reg <= finish(32'(z5_reg));
        end
    end

    assign pos_x = x_reg;
    assign pos_y = y_reg;
    assign pos_z = z_reg;

endmodule

@@ hw/rtl/arm_forward_kinematics_unit.sv @@
// Arm forward kinematics: four joint angles in, end-effector x, y, z out.
// One word per cycle sustained while results are taken.
// The pipeline advances whenever the output register is empty or being taken.
// Reset clears the valid pipeline and loads register defaults; no clearing pass.
// Depends on fkin_pkg, fkin_if, fkin_trig_lane, fkin_merge.
`timescale 1ns / 1ps
module arm_forward_kinematics_unit (
    input  logic        clk,
    input  logic        rst_n,
    fkin_joint_if.sink  joint,
    fkin_pos_if.source  pos,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import fkin_pkg::*;

    fkin_cfg_t          cfg_reg;
    logic [PIPE_LAT-1:0] vld_reg;
    logic               en;
    logic [33:0]        k;
    logic signed [15:0] ang [LANES];
    logic [47:0]        prod_reg [LANES];
    logic [31:0]        phase_reg [LANES];
    logic [31:0]        lane_phase [LANES];
    fkin_trig_t         trig [LANES];
    logic [47:0]        rnd_sum [LANES];

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle_unit      <= 1'b0;
            cfg_reg.base_height     <= 16'd2949;
            cfg_reg.shoulder_height <= 16'd1638;
            cfg_reg.upper_link      <= 16'd6226;
            cfg_reg.lower_link      <= 16'd6881;
            cfg_reg.tool_link       <= 16'd4915;
            cfg_reg.shoulder_offset <= 16'd393;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[4:2])
                REG_ANGLE_UNIT:      cfg_reg.angle_unit      <= pwdata[0];
                REG_BASE_HEIGHT:     cfg_reg.base_height     <= pwdata[15:0];
                REG_SHOULDER_HEIGHT: cfg_reg.shoulder_height <= pwdata[15:0];
                REG_UPPER_LINK:      cfg_reg.upper_link      <= pwdata[15:0];
                REG_LOWER_LINK:      cfg_reg.lower_link      <= pwdata[15:0];
                REG_TOOL_LINK:       cfg_reg.tool_link       <= pwdata[15:0];
                REG_SHOULDER_OFFSET: cfg_reg.shoulder_offset <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_ANGLE_UNIT:      prdata = {31'd0, cfg_reg.angle_unit};
            REG_BASE_HEIGHT:     prdata = {16'd0, cfg_reg.base_height};
            REG_SHOULDER_HEIGHT: prdata = {16'd0, cfg_reg.shoulder_height};
            REG_UPPER_LINK:      prdata = {16'd0, cfg_reg.upper_link};
            REG_LOWER_LINK:      prdata = {16'd0, cfg_reg.lower_link};
            REG_TOOL_LINK:       prdata = {16'd0, cfg_reg.tool_link};
            REG_SHOULDER_OFFSET: prdata = {16'd0, cfg_reg.shoulder_offset};
            default:             prdata = 32'd0;
        endcase
    end

    assign en          = !vld_reg[PIPE_LAT-1] || pos.ready;
    assign joint.ready = en;
    assign pos.valid   = vld_reg[PIPE_LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[PIPE_LAT-2:0], joint.valid};
    end

    assign k      = cfg_reg.angle_unit ? K_DEGREES : K_RADIANS;
    assign ang[0] = joint.joint0_angle;
    assign ang[1] = joint.joint1_angle;
    assign ang[2] = joint.joint2_angle;
    assign ang[3] = joint.joint3_angle;

    for (genvar i = 0; i < LANES; i++)
    begin : g_phase
        assign rnd_sum[i] = prod_reg[i] + 48'd32768;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                prod_reg[i]  <= 48'(ang[i]) * 48'($signed({1'b0, k}));
                phase_reg[i] <= rnd_sum[i][47:16];
            end
        end
    end

    // lane 3 works on the elbow-minus-wrist difference angle
    assign lane_phase[0] = phase_reg[0];
    assign lane_phase[1] = phase_reg[1];
    assign lane_phase[2] = phase_reg[2];
    assign lane_phase[3] = phase_reg[2] - phase_reg[3];

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        fkin_trig_lane u_lane (
            .clk   (clk),
            .en    (en),
            .phase (lane_phase[i]),
            .trig  (trig[i])
        );
    end

    fkin_merge u_merge (
        .clk   (clk),
        .en    (en),
        .cfg   (cfg_reg),
        .trig  (trig),
        .pos_x (pos.pos_x),
        .pos_y (pos.pos_y),
        .pos_z (pos.pos_z)
    );

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for arm_forward_kinematics_unit: joint angle words in, x/y/z out.
// Depends on fkin_pkg, fkin_if and the RTL; an internal fixed-point predictor supplies expectations.
`timescale 1ns / 1ps
module testbench;
    import fkin_pkg::*;

    typedef struct packed {
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic signed [17:0] z;
    } pos_word_t;

    typedef struct {
        logic signed [15:0] a0;
        logic signed [15:0] a1;
        logic signed [15:0] a2;
        logic signed [15:0] a3;
        bit                 known;
        pos_word_t          want;
    } joint_row_t;

    localparam int MAX_CYCLES = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    fkin_joint_if joint_ch ();
    fkin_pos_if   pos_ch ();

    fkin_cfg_t   cfg;
    pos_word_t   pending_pos[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          gaps_on = 1'b1;
    joint_row_t  rows[$];

    arm_forward_kinematics_unit dut (
        .clk(clk), .rst_n(rst_n), .joint(joint_ch.sink), .pos(pos_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 clk = ~clk;

    initial begin
        joint_ch.valid = 1'b0;
        joint_ch.joint0_angle = '0;
        joint_ch.joint1_angle = '0;
        joint_ch.joint2_angle = '0;
        joint_ch.joint3_angle = '0;
        pos_ch.ready = 1'b0;
    end

    // floor((v + 2^(n-1)) / 2^n), arithmetic shift floors
    function automatic longint rnd_shift(longint v, int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic logic [31:0] angle_phase(logic signed [15:0] a);
        logic [63:0] k;
        logic [63:0] p;
        k = cfg.angle_unit ? 64'(K_DEGREES) : 64'(K_RADIANS);
        p = 64'(longint'(a)) * k + 64'h8000;
        return p[47:16];
    endfunction

    function automatic void trig(logic [31:0] p, output longint sn, output longint cs);
        logic [63:0] r, rr, x, x2, t;
        longint s, c, tmp;
        bit fold;
        r = {34'd0, p[29:0]};
        fold = r > 64'h2000_0000;
        rr = fold ? (64'h4000_0000 - r) : r;
        x = (rr * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        t = 64'h4000_0000;
        foreach (SIN_DIV[i]) t = 64'h4000_0000 - ((x2 * t) >> 30) / SIN_DIV[i];
        s = longint'((x * t) >> 30);
        t = 64'h4000_0000;
        foreach (COS_DIV[i]) t = 64'h4000_0000 - ((x2 * t) >> 30) / COS_DIV[i];
        c = longint'(t);
        if (fold) begin
            tmp = s;
            s = c;
            c = tmp;
        end
        case (p[31:30])
            2'd0: begin sn = s; cs = c; end
            2'd1: begin sn = c; cs = -s; end
            2'd2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
        endcase
    endfunction

    function automatic logic signed [17:0] to_pos(longint v);
        longint q;
        q = rnd_shift(v, 8);
        if (q > 131071) q = 131071;
        if (q < -131072) q = -131072;
        return 18'(q);
    endfunction

    function automatic longint mq(longint a, longint tr);
        return rnd_shift(a * tr, 30);
    endfunction

    function automatic pos_word_t end_effector(logic signed [15:0] a0, logic signed [15:0] a1,
                                               logic signed [15:0] a2, logic signed [15:0] a3);
        logic [31:0] p2, p3;
        longint s0, c0, s1, c1, s2, c2, sd, cd, u, w, r;
        pos_word_t res;
        p2 = angle_phase(a2);
        p3 = angle_phase(a3);
        trig(angle_phase(a0), s0, c0);
        trig(angle_phase(a1), s1, c1);
        trig(p2, s2, c2);
        trig(p2 - p3, sd, cd);
        u = -(mq(longint'(cfg.lower_link) << 8, c2) + mq(longint'(cfg.tool_link) << 8, cd));
        w = (longint'(cfg.upper_link) << 8) - mq(longint'(cfg.lower_link) << 8, s2)
            - mq(longint'(cfg.tool_link) << 8, sd);
        r = mq(u, c1) + mq(w, s1) + (longint'(cfg.shoulder_offset) << 8);
        res.x = to_pos(mq(r, c0));
        res.y = to_pos(mq(r, s0));
        res.z = to_pos(mq(w, c1) - mq(u, s1) + (longint'(cfg.shoulder_height) << 8)
                       + (longint'(cfg.base_height) << 8));
        return res;
    endfunction

    task automatic reg_write(logic [2:0] idx, logic [15:0] val);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'd0, val};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ANGLE_UNIT:      cfg.angle_unit = val[0];
            REG_BASE_HEIGHT:     cfg.base_height = val;
            REG_SHOULDER_HEIGHT: cfg.shoulder_height = val;
            REG_UPPER_LINK:      cfg.upper_link = val;
            REG_LOWER_LINK:      cfg.lower_link = val;
            REG_TOOL_LINK:       cfg.tool_link = val;
            REG_SHOULDER_OFFSET: cfg.shoulder_offset = val;
            default: ;
        endcase
    endtask

    task automatic send_word(logic signed [15:0] a0, logic signed [15:0] a1,
                             logic signed [15:0] a2, logic signed [15:0] a3);
        int gap;
        pos_word_t e;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            joint_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        joint_ch.valid <= 1'b1;
        joint_ch.joint0_angle <= a0;
        joint_ch.joint1_angle <= a1;
        joint_ch.joint2_angle <= a2;
        joint_ch.joint3_angle <= a3;
        e = end_effector(a0, a1, a2, a3);
        @(posedge clk);
        while (!joint_ch.ready) @(posedge clk);
        pending_pos.push_back(e);
        @(negedge clk);
    endtask

    task automatic drain();
        joint_ch.valid <= 1'b0;
        while (pending_pos.size() != 0) @(negedge clk);
        repeat (PIPE_LAT + 4) @(negedge clk);
    endtask

    task automatic run_random(int n);
        logic signed [15:0] a[4];
        for (int i = 0; i < n; i++) begin
            foreach (a[j]) begin
                if ($urandom_range(0, 7) == 0)
                    a[j] = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                else
                    a[j] = 16'($urandom);
            end
            send_word(a[0], a[1], a[2], a[3]);
        end
    endtask

    // receiver: random stall bursts, none once gaps_on drops
    initial begin
        int stall;
        forever begin
            @(negedge clk);
            if (gaps_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 17);
                pos_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pos_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        pos_word_t got, want;
        if (rst_n && pos_ch.valid && pos_ch.ready) begin
            got.x = pos_ch.pos_x;
            got.y = pos_ch.pos_y;
            got.z = pos_ch.pos_z;
            if (pending_pos.size() == 0) begin
                $display("%0t: unexpected word x=%0d y=%0d z=%0d", $time, got.x, got.y, got.z);
                fail_count++;
            end else begin
                want = pending_pos.pop_front();
                if (got.x !== want.x) begin
                    $display("%0t: pos_x expected %0d actual %0d", $time, want.x, got.x);
                    fail_count++;
                end
                if (got.y !== want.y) begin
                    $display("%0t: pos_y expected %0d actual %0d", $time, want.y, got.y);
                    fail_count++;
                end
                if (got.z !== want.z) begin
                    $display("%0t: pos_z expected %0d actual %0d", $time, want.z, got.z);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > MAX_CYCLES) begin
            $display("arm_forward_kinematics_unit verification failed");
            $finish;
        end
    end

    task automatic add_row(logic signed [15:0] a0, logic signed [15:0] a1,
                           logic signed [15:0] a2, logic signed [15:0] a3,
                           bit known, pos_word_t want);
        joint_row_t r;
        r.a0 = a0;
        r.a1 = a1;
        r.a2 = a2;
        r.a3 = a3;
        r.known = known;
        r.want = want;
        rows.push_back(r);
    endtask

    initial begin
        pos_word_t w;
        pos_word_t none;
        none = '0;
        cfg = '{1'b0, 16'd2949, 16'd1638, 16'd6226, 16'd6881, 16'd4915, 16'd393};
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // all zero angles with default geometry: x = 393 - 6881 - 4915, z = 6226 + 1638 + 2949
        add_row(0, 0, 0, 0, 1'b1, '{-18'sd11403, 18'sd0, 18'sd10813});
        add_row(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, none);
        add_row(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, none);
        add_row(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b0, none);
        add_row(16'sh8000, 0, 16'sh7fff, 16'sh8000, 1'b0, none);
        add_row(12868, 0, 0, 0, 1'b0, none);
        add_row(0, 12868, 0, 0, 1'b0, none);
        add_row(0, 0, 12868, 12868, 1'b0, none);
        add_row(-25736, 6434, -6434, 25736, 1'b0, none);
        add_row(-1, 1, -1, 1, 1'b0, none);
        foreach (rows[i]) begin
            w = rows[i].known ? rows[i].want : end_effector(rows[i].a0, rows[i].a1,
                                                            rows[i].a2, rows[i].a3);
            if (rows[i].known && w !== end_effector(rows[i].a0, rows[i].a1,
                                                    rows[i].a2, rows[i].a3)) begin
                $display("%0t: table row %0d expected %p actual prediction differs",
                         $time, i, w);
                fail_count++;
            end
            send_word(rows[i].a0, rows[i].a1, rows[i].a2, rows[i].a3);
            pending_pos[pending_pos.size() - 1] = w;
        end
        run_random(140);
        drain();

        // degrees, all lengths at maximum: saturation
        reg_write(REG_ANGLE_UNIT, 16'd1);
        reg_write(REG_BASE_HEIGHT, 16'hffff);
        reg_write(REG_SHOULDER_HEIGHT, 16'hffff);
        reg_write(REG_UPPER_LINK, 16'hffff);
        reg_write(REG_LOWER_LINK, 16'hffff);
        reg_write(REG_TOOL_LINK, 16'hffff);
        reg_write(REG_SHOULDER_OFFSET, 16'hffff);
        send_word(0, 0, 0, 0);
        send_word(11520, 5760, -5760, 11520);
        send_word(16'sh7fff, 16'sh8000, 0, 16'sh7fff);
        run_random(140);
        drain();

        // all lengths zero
        reg_write(REG_BASE_HEIGHT, 16'd0);
        reg_write(REG_SHOULDER_HEIGHT, 16'd0);
        reg_write(REG_UPPER_LINK, 16'd0);
        reg_write(REG_LOWER_LINK, 16'd0);
        reg_write(REG_TOOL_LINK, 16'd0);
        reg_write(REG_SHOULDER_OFFSET, 16'd0);
        run_random(60);
        drain();

        // random geometry, both angle units
        for (int ph = 0; ph < 4; ph++) begin
            reg_write(REG_ANGLE_UNIT, 16'(ph & 1));
            reg_write(REG_BASE_HEIGHT, 16'($urandom));
            reg_write(REG_SHOULDER_HEIGHT, 16'($urandom));
            reg_write(REG_UPPER_LINK, 16'($urandom_range(0, 16383)));
            reg_write(REG_LOWER_LINK, 16'($urandom_range(0, 16383)));
            reg_write(REG_TOOL_LINK, 16'($urandom_range(0, 16383)));
            reg_write(REG_SHOULDER_OFFSET, 16'($urandom));
            if (ph == 3) gaps_on = 1'b0;
            run_random(90);
            drain();
        end

        if (fail_count == 0)
            $display("arm_forward_kinematics_unit verification clean");
        else
            $display("arm_forward_kinematics_unit verification failed");
        $finish;
    end
endmodule
